// ===== sv/tlsrd_pkg.sv =====
// ----------------------------------------------------------------------------
// TLS record deframer package
// Shared types, codes and constants of the TLS record deframer.
// ----------------------------------------------------------------------------
package tlsrd_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_BODY_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_MINOR_VER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_MINOR_VER = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration reset values.
  localparam logic [15:0] MAX_BODY_LEN_RST  = 16'd16640;
  localparam logic [7:0]  MIN_MINOR_VER_RST = 8'd1;
  localparam logic [7:0]  MAX_MINOR_VER_RST = 8'd4;

  // Header checks.
  localparam logic [7:0] CONTENT_TYPE_LO = 8'd20;
  localparam logic [7:0] CONTENT_TYPE_HI = 8'd23;
  localparam logic [7:0] MAJOR_VERSION   = 8'd3;

  // Header store slots.
  localparam logic [1:0] HDR_IDX_TYPE   = 2'd0;
  localparam logic [1:0] HDR_IDX_MAJOR  = 2'd1;
  localparam logic [1:0] HDR_IDX_MINOR  = 2'd2;
  localparam logic [1:0] HDR_IDX_LEN_HI = 2'd3;

  typedef enum logic [1:0] {
    PHASE_HEADER = 2'd0,
    PHASE_BODY   = 2'd1,
    PHASE_DROP   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_BODY    = 2'd1,
    KIND_INVALID = 2'd2
  } kind_t;

  typedef struct packed {
    logic [15:0] max_body_length;
    logic [7:0]  min_minor_version;
    logic [7:0]  max_minor_version;
  } cfg_t;

  typedef struct packed {
    kind_t       item_kind;
    logic [7:0]  content_type;
    logic [7:0]  minor_version;
    logic [15:0] body_length;
    logic [7:0]  body_byte;
    logic        record_last;
  } res_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] body_remaining;
  } stat_t;

endpackage

// ===== sv/tlsrd_in_if.sv =====
// ----------------------------------------------------------------------------
// TLS record deframer input channel
// Valid/ready channel that carries one raw stream byte per request.
// ----------------------------------------------------------------------------
interface tlsrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

// ===== sv/tlsrd_out_if.sv =====
// ----------------------------------------------------------------------------
// TLS record deframer result channel
// Valid/ready channel that carries one header, body or invalid result.
// ----------------------------------------------------------------------------
interface tlsrd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [7:0]  content_type;
  logic [7:0]  minor_version;
  logic [15:0] body_length;
  logic [7:0]  body_byte;
  logic        record_last;

  modport source (
    output valid, output item_kind, output content_type, output minor_version,
    output body_length, output body_byte, output record_last, input ready
  );
  modport sink (
    input valid, input item_kind, input content_type, input minor_version,
    input body_length, input body_byte, input record_last, output ready
  );
endinterface

// ===== sv/tlsrd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// TLS record deframer configuration registers
// Holds the length limit and the minor version bounds.
// ----------------------------------------------------------------------------
module tlsrd_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tlsrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlsrd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output tlsrd_pkg::cfg_t                    cfg
);

  tlsrd_pkg::cfg_t cfg_r;
  tlsrd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tlsrd_pkg::CFG_IDX_MAX_BODY_LEN:  cfg_nxt.max_body_length   = cfg_wdata;
        tlsrd_pkg::CFG_IDX_MIN_MINOR_VER: cfg_nxt.min_minor_version = cfg_wdata[7:0];
        tlsrd_pkg::CFG_IDX_MAX_MINOR_VER: cfg_nxt.max_minor_version = cfg_wdata[7:0];
        default: ;  // Writes beyond the register list are ignored.
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_body_length   <= tlsrd_pkg::MAX_BODY_LEN_RST;
      cfg_r.min_minor_version <= tlsrd_pkg::MIN_MINOR_VER_RST;
      cfg_r.max_minor_version <= tlsrd_pkg::MAX_MINOR_VER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/tlsrd_parser.sv =====
// ----------------------------------------------------------------------------
// TLS record deframer parser
// Record state and the single-pass header check and body count.
// ----------------------------------------------------------------------------
module tlsrd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        stream_byte,
  input  tlsrd_pkg::cfg_t   cfg,
  output logic              res_valid,
  output tlsrd_pkg::res_t   res,
  output tlsrd_pkg::stat_t  stat
);

  tlsrd_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]        pos_r, pos_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [7:0]        hdr_r [4];

  logic              hdr_we;
  logic [1:0]        hdr_widx;
  logic [15:0]       hdr_len;
  logic [15:0]       rem_dec;
  logic              hdr_ok;

  always_comb begin
    hdr_len = {hdr_r[tlsrd_pkg::HDR_IDX_LEN_HI], stream_byte};
    rem_dec = rem_r - 16'd1;
    hdr_ok  = (hdr_r[tlsrd_pkg::HDR_IDX_TYPE] >= tlsrd_pkg::CONTENT_TYPE_LO)
           && (hdr_r[tlsrd_pkg::HDR_IDX_TYPE] <= tlsrd_pkg::CONTENT_TYPE_HI)
           && (hdr_r[tlsrd_pkg::HDR_IDX_MAJOR] == tlsrd_pkg::MAJOR_VERSION)
           && (hdr_r[tlsrd_pkg::HDR_IDX_MINOR] >= cfg.min_minor_version)
           && (hdr_r[tlsrd_pkg::HDR_IDX_MINOR] <= cfg.max_minor_version)
           && (hdr_len <= cfg.max_body_length);

    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    hdr_we    = 1'b0;
    hdr_widx  = pos_r[1:0];
    res_valid = 1'b0;
    res.item_kind     = tlsrd_pkg::KIND_HEADER;
    res.content_type  = hdr_r[tlsrd_pkg::HDR_IDX_TYPE];
    res.minor_version = hdr_r[tlsrd_pkg::HDR_IDX_MINOR];
    res.body_length   = hdr_len;
    res.body_byte     = 8'd0;
    res.record_last   = 1'b0;

    unique case (phase_r)
      tlsrd_pkg::PHASE_HEADER: begin
        if (!pos_r[2]) begin
          // Still collecting the first four header bytes.
          hdr_we  = 1'b1;
          pos_nxt = pos_r + 3'd1;
        end else begin
          // Fifth byte completes the length; check the whole header now.
          pos_nxt   = 3'd0;
          res_valid = 1'b1;
          if (!hdr_ok) begin
            phase_nxt       = tlsrd_pkg::PHASE_DROP;
            res.item_kind   = tlsrd_pkg::KIND_INVALID;
            res.record_last = 1'b1;
          end else begin
            // The major version slot now keeps the low length byte.
            hdr_we   = 1'b1;
            hdr_widx = tlsrd_pkg::HDR_IDX_MAJOR;
            if (hdr_len == 16'd0) begin
              res.record_last = 1'b1;
            end else begin
              rem_nxt   = hdr_len;
              phase_nxt = tlsrd_pkg::PHASE_BODY;
            end
          end
        end
      end
      tlsrd_pkg::PHASE_BODY: begin
        rem_nxt         = rem_dec;
        res_valid       = 1'b1;
        res.item_kind   = tlsrd_pkg::KIND_BODY;
        res.body_length = {hdr_r[tlsrd_pkg::HDR_IDX_LEN_HI], hdr_r[tlsrd_pkg::HDR_IDX_MAJOR]};
        res.body_byte   = stream_byte;
        if (rem_dec == 16'd0) begin
          res.record_last = 1'b1;
          phase_nxt       = tlsrd_pkg::PHASE_HEADER;
          pos_nxt         = 3'd0;
        end
      end
      default: ;  // Dropped: every byte is discarded until reset.
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tlsrd_pkg::PHASE_HEADER;
      pos_r   <= 3'd0;
      rem_r   <= 16'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hdr_we) begin
      hdr_r[hdr_widx] <= stream_byte;
    end
  end

  assign stat.phase          = phase_r;
  assign stat.body_remaining = rem_r;

endmodule

// ===== sv/tls_record_deframer_core.sv =====
// ----------------------------------------------------------------------------
// TLS record deframer core
// Splits a TLS byte stream into header, body and invalid-header results.
// ----------------------------------------------------------------------------
// The block takes one stream byte per request and sustains one byte per
// clock as long as the result side keeps taking results. A byte is held in
// the input register and is parsed in one pass against the record state.
// Its result (if any) is loaded into the output register once that
// register is free to take it, and is offered from there. The record state
// update (header collect, length check, body countdown) is made in the same
// pass. The first four header bytes give no result; the fifth gives either a
// header result or an invalid result, and each body byte gives one body
// result with record_last on the final one. After an invalid header the
// block keeps taking bytes but drops them all until reset. Configuration
// writes are registered and are meant to be made while idle.
// ----------------------------------------------------------------------------
module tls_record_deframer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  tlsrd_in_if.sink                          in_chan,
  tlsrd_out_if.source                       out_chan,
  input  logic                              cfg_we,
  input  logic [tlsrd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tlsrd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  tlsrd_pkg::cfg_t  cfg;
  tlsrd_pkg::res_t  res;
  tlsrd_pkg::stat_t stat;
  logic             res_valid;

  // Input register.
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;

  // Output register.
  logic            out_valid_r, out_valid_nxt;
  tlsrd_pkg::res_t out_res_r;

  logic out_free;
  logic step;

  // The parser advances whenever it holds a byte and the output register
  // can take whatever result that byte produces this cycle.
  assign out_free = !out_valid_r || out_chan.ready;
  assign step     = in_valid_r && out_free;

  // A new request is taken when the input register is empty or drains now.
  assign in_chan.ready = !in_valid_r || step;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_chan.ready) begin
      in_valid_nxt = in_chan.valid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (step) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.stream_byte;
    end
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  tlsrd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tlsrd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .stream_byte (in_byte_r),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res),
    .stat        (stat)
  );

  assign out_chan.valid         = out_valid_r;
  assign out_chan.item_kind     = out_res_r.item_kind;
  assign out_chan.content_type  = out_res_r.content_type;
  assign out_chan.minor_version = out_res_r.minor_version;
  assign out_chan.body_length   = out_res_r.body_length;
  assign out_chan.body_byte     = out_res_r.body_byte;
  assign out_chan.record_last   = out_res_r.record_last;

  // Once an invalid result has been taken, the block never offers another.
  a_invalid_is_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chan.ready && out_res_r.item_kind == tlsrd_pkg::KIND_INVALID)
    |=> !out_valid_r)
    else $error("result offered after an invalid header");

  // In the body phase at least one body byte is always still owed.
  a_body_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.phase == tlsrd_pkg::PHASE_BODY) |-> (stat.body_remaining != 16'd0))
    else $error("body phase with no body bytes remaining");

  // An invalid header always closes its record.
  a_invalid_closes_record: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.item_kind == tlsrd_pkg::KIND_INVALID)
    |-> out_res_r.record_last)
    else $error("invalid result without record_last");

endmodule
